[hdl/hbc_pkg.sv]
// Types, constants and table functions for the header block codec.
package hbc_pkg;

  localparam int unsigned WORD_BITS = 25;
  localparam int unsigned LEN_BITS  = 17;
  localparam int unsigned FEC_BITS  = 5;
  localparam int unsigned FIX_BITS  = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [LEN_BITS-1:0]  len_t;
  typedef logic [FEC_BITS-1:0]  syn_t;
  typedef logic [FIX_BITS-1:0]  fix_t;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam word_t CHECK_ROW0 = 25'h001FFF0;
  localparam word_t CHECK_ROW1 = 25'h07E1FE8;
  localparam word_t CHECK_ROW2 = 25'h18E61E4;
  localparam word_t CHECK_ROW3 = 25'h1B6A662;
  localparam word_t CHECK_ROW4 = 25'h0D3CAA1;

  typedef struct packed {
    word_t pattern;
    fix_t  weight;
  } fix_entry_t;

  // Error pattern and its weight for each syndrome.
  function automatic fix_entry_t fix_lookup(input syn_t syn);
    fix_entry_t e;
    unique case (syn)
      5'd0:  e = '{25'h0000000, 2'd0};
      5'd1:  e = '{25'h0000001, 2'd1};
      5'd2:  e = '{25'h0000002, 2'd1};
      5'd3:  e = '{25'h0800004, 2'd2};
      5'd4:  e = '{25'h0000004, 2'd1};
      5'd5:  e = '{25'h0800002, 2'd2};
      5'd6:  e = '{25'h1000000, 2'd1};
      5'd7:  e = '{25'h0800000, 2'd1};
      5'd8:  e = '{25'h0000008, 2'd1};
      5'd9:  e = '{25'h0400000, 2'd1};
      5'd10: e = '{25'h0200000, 2'd1};
      5'd11: e = '{25'h0100000, 2'd1};
      5'd12: e = '{25'h0080000, 2'd1};
      5'd13: e = '{25'h1100000, 2'd2};
      5'd14: e = '{25'h0040000, 2'd1};
      5'd15: e = '{25'h0020000, 2'd1};
      5'd16: e = '{25'h0000010, 2'd1};
      5'd17: e = '{25'h0010000, 2'd1};
      5'd18: e = '{25'h0804000, 2'd2};
      5'd19: e = '{25'h0008000, 2'd1};
      5'd20: e = '{25'h0808000, 2'd2};
      5'd21: e = '{25'h0004000, 2'd1};
      5'd22: e = '{25'h0002000, 2'd1};
      5'd23: e = '{25'h1010000, 2'd2};
      5'd24: e = '{25'h0001000, 2'd1};
      5'd25: e = '{25'h0000800, 2'd1};
      5'd26: e = '{25'h0000400, 2'd1};
      5'd27: e = '{25'h0000200, 2'd1};
      5'd28: e = '{25'h0000100, 2'd1};
      5'd29: e = '{25'h0000080, 2'd1};
      5'd30: e = '{25'h0000040, 2'd1};
      5'd31: e = '{25'h0000020, 2'd1};
      default: e = '{25'h0000000, 2'd0};
    endcase
    return e;
  endfunction

  // Bit reversal of the length field.
  function automatic len_t flip_len(input len_t x);
    len_t r;
    for (int i = 0; i < LEN_BITS; i++) begin
      r[i] = x[LEN_BITS-1-i];
    end
    return r;
  endfunction

endpackage

[hdl/hbc_req_if.sv]
// Request channel of the header block codec.
interface hbc_req_if;
  logic           valid;
  logic           ready;
  logic           action;
  hbc_pkg::word_t received_word;
  hbc_pkg::len_t  length_to_encode;

  modport source (output valid, action, received_word, length_to_encode, input ready);
  modport sink (input valid, action, received_word, length_to_encode, output ready);
endinterface

[hdl/hbc_rsp_if.sv]
// Response channel of the header block codec.
interface hbc_rsp_if;
  logic           valid;
  logic           ready;
  hbc_pkg::word_t code_word;
  hbc_pkg::len_t  decoded_length;
  hbc_pkg::fix_t  bits_corrected;
  logic           status;

  modport source (output valid, code_word, decoded_length, bits_corrected, status,
                  input ready);
  modport sink (input valid, code_word, decoded_length, bits_corrected, status,
                output ready);
endinterface

[hdl/header_block_code_codec.sv]
// Top level of the (25,20) header block codec, a three-stage pipeline.
// Throughput is one word per cycle; a stalled response holds the output stage,
// and earlier stages move on only when the next stage is empty or moving on.
// Stages are body formation, syndrome, then pattern lookup and correction.
// Reset (synchronous, active high) clears the stage valid bits only.
module header_block_code_codec (
  input  logic      clk,
  input  logic      rst,
  hbc_req_if.sink   req,
  hbc_rsp_if.source rsp
);

  logic           v1, v2, v3;
  logic           adv1, adv2, adv3;
  logic           act1, act2;
  hbc_pkg::word_t body1, body2;
  hbc_pkg::syn_t  syn2;

  hbc_pkg::word_t     body_next;
  hbc_pkg::syn_t      syn_next;
  hbc_pkg::fix_entry_t fix;
  hbc_pkg::word_t     fixed_word;
  hbc_pkg::word_t     code_word_next;
  hbc_pkg::len_t      length_next;
  hbc_pkg::fix_t      bits_next;
  logic               status_next;

  hbc_pkg::word_t code_word;
  hbc_pkg::len_t  decoded_length;
  hbc_pkg::fix_t  bits_corrected;
  logic           status;

  assign adv3      = !v3 || rsp.ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req.ready = adv1;

  always_comb begin
    if (req.action == hbc_pkg::ACT_ENCODE) begin
      body_next = {3'b000, hbc_pkg::flip_len(req.length_to_encode),
                   {hbc_pkg::FEC_BITS{1'b0}}};
    end else begin
      body_next = {3'b000, req.received_word[21:0]};
    end
  end

  always_comb begin
    syn_next[4] = ^(body1 & hbc_pkg::CHECK_ROW0);
    syn_next[3] = ^(body1 & hbc_pkg::CHECK_ROW1);
    syn_next[2] = ^(body1 & hbc_pkg::CHECK_ROW2);
    syn_next[1] = ^(body1 & hbc_pkg::CHECK_ROW3);
    syn_next[0] = ^(body1 & hbc_pkg::CHECK_ROW4);
  end

  always_comb begin
    fix        = hbc_pkg::fix_lookup(syn2);
    fixed_word = body2 ^ fix.pattern;
    if (act2 == hbc_pkg::ACT_ENCODE) begin
      code_word_next = body2 | {20'd0, syn2};
      length_next    = '0;
      bits_next      = '0;
      status_next    = hbc_pkg::STATUS_OK;
    end else if (|fix.pattern[24:22]) begin
      code_word_next = '0;
      length_next    = '0;
      bits_next      = '0;
      status_next    = hbc_pkg::STATUS_FAIL;
    end else begin
      code_word_next = fixed_word;
      length_next    = hbc_pkg::flip_len(fixed_word[21:5]);
      bits_next      = fix.weight;
      status_next    = hbc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= req.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      act1  <= req.action;
      body1 <= body_next;
    end
    if (adv2) begin
      act2  <= act1;
      body2 <= body1;
      syn2  <= syn_next;
    end
    if (adv3) begin
      code_word      <= code_word_next;
      decoded_length <= length_next;
      bits_corrected <= bits_next;
      status         <= status_next;
    end
  end

  assign rsp.valid          = v3;
  assign rsp.code_word      = code_word;
  assign rsp.decoded_length = decoded_length;
  assign rsp.bits_corrected = bits_corrected;
  assign rsp.status         = status;

endmodule

[verif/hbc_checker.sv]
// Checker that predicts and compares every response word of the header block codec.
module hbc_checker (
  input  logic clk,
  input  logic rst,
  hbc_req_if   req,
  hbc_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   words_checked,
  output int   decode_failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam hbc_pkg::word_t BODY_MASK = 25'h03FFFFF;

  typedef struct packed {
    hbc_pkg::word_t code_word;
    hbc_pkg::len_t  decoded_length;
    hbc_pkg::fix_t  bits_corrected;
    logic           status;
  } header_result_t;

  header_result_t awaiting_words[$];

  function automatic hbc_pkg::word_t check_row(input int i);
    case (i)
      0: return hbc_pkg::CHECK_ROW0;
      1: return hbc_pkg::CHECK_ROW1;
      2: return hbc_pkg::CHECK_ROW2;
      3: return hbc_pkg::CHECK_ROW3;
      default: return hbc_pkg::CHECK_ROW4;
    endcase
  endfunction

  function automatic hbc_pkg::word_t error_pattern(input hbc_pkg::syn_t syn);
    case (syn)
      5'd0:  return 25'h0000000;
      5'd1:  return 25'h0000001;
      5'd2:  return 25'h0000002;
      5'd3:  return 25'h0800004;
      5'd4:  return 25'h0000004;
      5'd5:  return 25'h0800002;
      5'd6:  return 25'h1000000;
      5'd7:  return 25'h0800000;
      5'd8:  return 25'h0000008;
      5'd9:  return 25'h0400000;
      5'd10: return 25'h0200000;
      5'd11: return 25'h0100000;
      5'd12: return 25'h0080000;
      5'd13: return 25'h1100000;
      5'd14: return 25'h0040000;
      5'd15: return 25'h0020000;
      5'd16: return 25'h0000010;
      5'd17: return 25'h0010000;
      5'd18: return 25'h0804000;
      5'd19: return 25'h0008000;
      5'd20: return 25'h0808000;
      5'd21: return 25'h0004000;
      5'd22: return 25'h0002000;
      5'd23: return 25'h1010000;
      5'd24: return 25'h0001000;
      5'd25: return 25'h0000800;
      5'd26: return 25'h0000400;
      5'd27: return 25'h0000200;
      5'd28: return 25'h0000100;
      5'd29: return 25'h0000080;
      5'd30: return 25'h0000040;
      default: return 25'h0000020;
    endcase
  endfunction

  function automatic hbc_pkg::len_t reverse_len(input hbc_pkg::len_t x);
    hbc_pkg::len_t r;
    r = '0;
    for (int i = 0; i < hbc_pkg::LEN_BITS; i++) begin
      r = {r[hbc_pkg::LEN_BITS-2:0], x[i]};
    end
    return r;
  endfunction

  function automatic hbc_pkg::word_t encode_length(input hbc_pkg::len_t len);
    hbc_pkg::word_t w;
    w = {3'b000, reverse_len(len), 5'b00000};
    for (int i = 0; i < hbc_pkg::FEC_BITS; i++) begin
      if (^(w & check_row(i))) w[hbc_pkg::FEC_BITS-1-i] = 1'b1;
    end
    return w;
  endfunction

  function automatic header_result_t decode_header(input hbc_pkg::word_t rx);
    header_result_t r;
    hbc_pkg::word_t body;
    hbc_pkg::word_t pat;
    hbc_pkg::syn_t syn;
    body = rx & BODY_MASK;
    for (int i = 0; i < hbc_pkg::FEC_BITS; i++) begin
      syn[hbc_pkg::FEC_BITS-1-i] = ^(body & check_row(i));
    end
    pat = error_pattern(syn);
    body = body ^ pat;
    r = '0;
    if ((body & ~BODY_MASK) != '0) begin
      r.status = hbc_pkg::STATUS_FAIL;
    end else begin
      r.code_word = body;
      r.decoded_length = reverse_len(body[hbc_pkg::FEC_BITS +: hbc_pkg::LEN_BITS]);
      r.bits_corrected = hbc_pkg::fix_t'($countones(pat));
      r.status = hbc_pkg::STATUS_OK;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    header_result_t exp_word;
    if (rst) begin
      fail_count = 0;
      pending = 0;
      words_checked = 0;
      decode_failures = 0;
      awaiting_words.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaiting_words.size() == 0) begin
          $error("response word with no request outstanding");
          fail_count++;
        end else begin
          exp_word = awaiting_words.pop_front();
          words_checked++;
          if (exp_word.status == hbc_pkg::STATUS_FAIL) decode_failures++;
          if (rsp.code_word !== exp_word.code_word) begin
            $error("code_word expected %h got %h", exp_word.code_word, rsp.code_word);
            fail_count++;
          end
          if (rsp.decoded_length !== exp_word.decoded_length) begin
            $error("decoded_length expected %h got %h",
                   exp_word.decoded_length, rsp.decoded_length);
            fail_count++;
          end
          if (rsp.bits_corrected !== exp_word.bits_corrected) begin
            $error("bits_corrected expected %0d got %0d",
                   exp_word.bits_corrected, rsp.bits_corrected);
            fail_count++;
          end
          if (rsp.status !== exp_word.status) begin
            $error("status expected %b got %b", exp_word.status, rsp.status);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.action == hbc_pkg::ACT_DECODE) begin
          awaiting_words.push_back(decode_header(req.received_word));
        end else begin
          exp_word = '0;
          exp_word.code_word = encode_length(req.length_to_encode);
          exp_word.status = hbc_pkg::STATUS_OK;
          awaiting_words.push_back(exp_word);
        end
      end
      pending = awaiting_words.size();
    end
  end

endmodule

[verif/tb.sv]
// Top of the header block codec testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam hbc_pkg::word_t RESERVED_BITS = 25'h1C00000;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   encodes_sent;
  int   decodes_sent;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   words_checked;
  int   decode_failures;

  hbc_req_if req ();
  hbc_rsp_if rsp ();

  header_block_code_codec dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  hbc_checker chk (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .rsp             (rsp),
    .fail_count      (fail_count),
    .pending         (pending),
    .words_checked   (words_checked),
    .decode_failures (decode_failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(input logic act, input hbc_pkg::word_t rx,
                           input hbc_pkg::len_t len);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.received_word <= rx;
    req.length_to_encode <= len;
    if (act == hbc_pkg::ACT_DECODE) decodes_sent++;
    else encodes_sent++;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic hbc_pkg::len_t pick_length();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return hbc_pkg::len_t'($urandom_range(17'h1FFFF));
    endcase
  endfunction

  task automatic run_directed();
    hbc_pkg::word_t cw;
    send_word(hbc_pkg::ACT_ENCODE, '1, 17'h00000);
    send_word(hbc_pkg::ACT_ENCODE, '0, 17'h1FFFF);
    send_word(hbc_pkg::ACT_ENCODE, '0, 17'h15555);
    send_word(hbc_pkg::ACT_ENCODE, '1, 17'h0AAAA);
    send_word(hbc_pkg::ACT_ENCODE, '0, 17'h00001);
    send_word(hbc_pkg::ACT_ENCODE, '0, 17'h10000);
    send_word(hbc_pkg::ACT_DECODE, 25'h0000000, '1);
    send_word(hbc_pkg::ACT_DECODE, 25'h1FFFFFF, '0);
    send_word(hbc_pkg::ACT_DECODE, RESERVED_BITS, '0);
    cw = chk.encode_length(17'h15555);
    send_word(hbc_pkg::ACT_DECODE, cw, '0);
    send_word(hbc_pkg::ACT_DECODE, cw | RESERVED_BITS, '0);
    cw = chk.encode_length(17'h0AAAA);
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0000001, '0);
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0000010, '0);
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0000020, '0);
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0200000, '0);
    // Two- and three-bit parity errors whose correction falls into the reserved bits.
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0000003, '0);
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0000006, '0);
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0000007, '0);
    cw = chk.encode_length(17'h1FFFF);
    send_word(hbc_pkg::ACT_DECODE, cw ^ 25'h0002000, '0);
  endtask

  task automatic run_random(input int count);
    hbc_pkg::word_t rx;
    int             pick;
    int             pos;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      rx = hbc_pkg::word_t'($urandom_range(25'h1FFFFFF));
      if (pick < 35) begin
        send_word(hbc_pkg::ACT_ENCODE, rx, pick_length());
      end else if (pick < 75) begin
        rx = chk.encode_length(pick_length());
        repeat ($urandom_range(3)) begin
          pos = $urandom_range(21);
          rx[pos] = ~rx[pos];
        end
        if ($urandom_range(1) == 1) rx[24:22] = 3'($urandom_range(7));
        send_word(hbc_pkg::ACT_DECODE, rx, hbc_pkg::len_t'($urandom_range(17'h1FFFF)));
      end else begin
        send_word(hbc_pkg::ACT_DECODE, rx, hbc_pkg::len_t'($urandom_range(17'h1FFFF)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.action = hbc_pkg::ACT_ENCODE;
    req.received_word = '0;
    req.length_to_encode = '0;
    send_idle_pct = 30;
    recv_idle_pct = 62;
    encodes_sent = 0;
    decodes_sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    run_random(450);
    drain();
    send_idle_pct = 62;
    recv_idle_pct = 30;
    run_random(450);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(450);
    drain();
    repeat (10) @(negedge clk);
    if (pending != 0) $error("%0d expected response words never arrived", pending);
    $display("Sent %0d encode and %0d decode words under three idle mixes.",
             encodes_sent, decodes_sent);
    $display("Checked %0d response words, %0d of them uncorrectable decodes.",
             words_checked, decode_failures);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
